// ----- hdl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Transaction structs, action/status codes and the controller state enum.
// No dependencies.
package deq_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 5;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_t;

  typedef struct packed {
    action_t              action;
    logic [VALUE_W-1:0]   data_in;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   popped_value;
    status_t              status;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;
    logic [VALUE_W-1:0]   front_value;
    logic [VALUE_W-1:0]   back_value;
  } res_t;

endpackage

// ----- hdl/deq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/double_ended_queue.sv -----
// Bounded double-ended queue on a ring buffer held in one RAM.
// Depends on deq_pkg and deq_ram.
//
//   channel | ports                | handshake
//   --------+----------------------+------------------------------------
//   command | cmd (cmd_t)          | taken when start && !busy
//   result  | result (res_t), done | done high one cycle, no backpressure
//
// In each transaction, the accept cycle issues the RAM read for
// the entry that becomes the new front or back after a pop, and the result
// is driven with the registered read data on the next cycle. busy is high
// during that result cycle. The front and back entries are cached in
// registers, so at most one RAM read is needed per transaction.
// Reset (rst, synchronous) empties the queue; RAM contents are not cleared.
module double_ended_queue #(
  parameter int CAPACITY   = deq_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  deq_pkg::cmd_t  cmd,
  output logic           done,
  output deq_pkg::res_t  result
);

  import deq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [IW-1:0]         head, head_next;
  logic [IW-1:0]         tail, tail_next;
  logic [CW-1:0]         count, count_next;
  logic [DATA_WIDTH-1:0] front_reg, front_next;
  logic [DATA_WIDTH-1:0] back_reg, back_next;
  logic [DATA_WIDTH-1:0] popped, popped_next;
  status_t               stat, stat_next;
  logic                  upd_front, upd_front_next;
  logic                  upd_back, upd_back_next;

  logic                  accept;
  logic                  is_full;
  logic                  is_zero;
  logic [DATA_WIDTH-1:0] push_val;
  logic [63:0]           din_ext;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] front_cur;
  logic [DATA_WIDTH-1:0] back_cur;

  function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] i);
    return (i == IW'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] slot_prev(input logic [IW-1:0] i);
    return (i == '0) ? IW'(CAPACITY - 1) : i - 1'b1;
  endfunction

  function automatic logic [VALUE_W-1:0] to_field(input logic [DATA_WIDTH-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[VALUE_W-1:0];
  endfunction

  assign accept   = start && (state == ST_IDLE);
  assign is_full  = (count == CW'(CAPACITY));
  assign is_zero  = (count == '0);
  assign din_ext  = 64'(cmd.data_in);
  assign push_val = din_ext[DATA_WIDTH-1:0];

  // Pops never write, and a pushed entry is read back no sooner than the
  // next transaction, so no read whose data is used meets a write to its address.
  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_val),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Cached ends, refreshed from the RAM read where a pop exposed a new end.
  assign front_cur = upd_front ? rdata : front_reg;
  assign back_cur  = upd_back  ? rdata : back_reg;

  // Transaction datapath: pointer, count and cache updates on accept; cache refresh from the RAM in ST_RESP.
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    front_next     = front_reg;
    back_next      = back_reg;
    popped_next    = popped;
    stat_next      = stat;
    upd_front_next = upd_front;
    upd_back_next  = upd_back;
    we             = 1'b0;
    waddr          = tail;
    raddr          = slot_next(head);

    if (accept) begin
      popped_next    = '0;
      stat_next      = STAT_OK;
      upd_front_next = 1'b0;
      upd_back_next  = 1'b0;
      unique case (cmd.action)
        ACT_PUSH_FRONT: begin
          if (is_full) begin
            stat_next = STAT_FULL;
          end else begin
            head_next  = slot_prev(head);
            waddr      = slot_prev(head);
            we         = 1'b1;
            count_next = count + 1'b1;
            front_next = push_val;
            if (is_zero) begin
              back_next = push_val;
            end
          end
        end
        ACT_PUSH_BACK: begin
          if (is_full) begin
            stat_next = STAT_FULL;
          end else begin
            waddr      = tail;
            we         = 1'b1;
            tail_next  = slot_next(tail);
            count_next = count + 1'b1;
            back_next  = push_val;
            if (is_zero) begin
              front_next = push_val;
            end
          end
        end
        ACT_POP_FRONT: begin
          if (is_zero) begin
            stat_next = STAT_EMPTY;
          end else begin
            popped_next    = front_reg;
            head_next      = slot_next(head);
            count_next     = count - 1'b1;
            raddr          = slot_next(head);
            upd_front_next = 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (is_zero) begin
            stat_next = STAT_EMPTY;
          end else begin
            popped_next   = back_reg;
            tail_next     = slot_prev(tail);
            count_next    = count - 1'b1;
            raddr         = slot_prev(slot_prev(tail));
            upd_back_next = 1'b1;
          end
        end
        default: begin
          stat_next = STAT_OK;
        end
      endcase
    end else if (state == ST_RESP) begin
      front_next     = front_cur;
      back_next      = back_cur;
      upd_front_next = 1'b0;
      upd_back_next  = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy                = (state != ST_IDLE);
    done                = (state == ST_RESP);
    result.popped_value = to_field(popped);
    result.status       = stat;
    result.entry_count  = COUNT_W'(count);
    result.is_empty     = is_zero;
    result.front_value  = is_zero ? '0 : to_field(front_cur);
    result.back_value   = is_zero ? '0 : to_field(back_cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      upd_front <= 1'b0;
      upd_back  <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      upd_front <= upd_front_next;
      upd_back  <= upd_back_next;
    end
  end

  always_ff @(posedge clk) begin
    front_reg <= front_next;
    back_reg  <= back_next;
    popped    <= popped_next;
    stat      <= stat_next;
  end

  // A result only follows an accepted transaction.
  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without accepted transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_FULL) |-> (count == CW'(CAPACITY)))
    else $error("full status with free space");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_EMPTY) |-> (count == '0 && popped == '0))
    else $error("empty status with stored entries");

  // Head and tail meet exactly when the ring is empty or full.
  a_ring_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(CAPACITY)) |-> (head == tail))
    else $error("ring pointers inconsistent with count");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for double_ended_queue: directed and random push/pop traffic.
// An internal deque predictor is checked against every result strobe.
// Depends on deq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  localparam int DEPTH       = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  res_t result;

  // predictor state: live entries, front at index 0
  logic [VALUE_W-1:0] deque_contents[$];
  res_t               pending_results[$];

  int errors      = 0;
  int items_sent  = 0;
  int push_count  = 0;
  int pop_count   = 0;
  int full_drops  = 0;
  int empty_pops  = 0;
  int idle_cycles = 0;
  bit sender_burst = 1'b0;
  res_t want_r;

  double_ended_queue u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic res_t predict_deque_op(input cmd_t c);
    res_t r;
    r = '0;
    r.status = STAT_OK;
    case (c.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (deque_contents.size() >= DEPTH) begin
          r.status = STAT_FULL;
          full_drops++;
        end else begin
          if (c.action == ACT_PUSH_FRONT) deque_contents.push_front(c.data_in);
          else deque_contents.push_back(c.data_in);
          push_count++;
        end
      end
      default: begin
        if (deque_contents.size() == 0) begin
          r.status = STAT_EMPTY;
          empty_pops++;
        end else begin
          if (c.action == ACT_POP_FRONT) r.popped_value = deque_contents.pop_front();
          else r.popped_value = deque_contents.pop_back();
          pop_count++;
        end
      end
    endcase
    r.entry_count = COUNT_W'(deque_contents.size());
    r.is_empty    = (deque_contents.size() == 0);
    if (deque_contents.size() != 0) begin
      r.front_value = deque_contents[0];
      r.back_value  = deque_contents[$];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (sender_burst || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // one transaction: optional idle gap, then hold start until the block takes it
  task automatic send_cmd(input action_t act, input logic [VALUE_W-1:0] value);
    int   gap;
    cmd_t c;
    gap = pick_gap();
    c.action  = act;
    c.data_in = value;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_deque_op(c));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, result);
      end else begin
        want_r = pending_results.pop_front();
        check_field("popped_value", want_r.popped_value, result.popped_value);
        check_field("status", VALUE_W'(want_r.status), VALUE_W'(result.status));
        check_field("entry_count", VALUE_W'(want_r.entry_count),
                    VALUE_W'(result.entry_count));
        check_field("is_empty", VALUE_W'(want_r.is_empty), VALUE_W'(result.is_empty));
        check_field("front_value",  want_r.front_value,  result.front_value);
        check_field("back_value",   want_r.back_value,   result.back_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_pop_on_empty();
    send_cmd(ACT_POP_FRONT, '1);
    send_cmd(ACT_POP_BACK, '1);
  endtask

  task automatic test_push_pop_extremes();
    send_cmd(ACT_PUSH_FRONT, '0);
    send_cmd(ACT_PUSH_BACK, '1);
    send_cmd(ACT_POP_FRONT, 32'h1234_5678);
    send_cmd(ACT_POP_BACK, 32'h8765_4321);
  endtask

  // fill from both ends, then try one more push on each end
  task automatic test_fill_to_overflow();
    for (int i = 0; i < DEPTH; i++) begin
      send_cmd(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
               i[1] ? 32'hAAAA_AAAA ^ VALUE_W'(i) : 32'h5555_5555 ^ VALUE_W'(i));
    end
    send_cmd(ACT_PUSH_FRONT, '1);
    send_cmd(ACT_PUSH_BACK, '0);
  endtask

  // episodes biased toward pushes, toward pops or balanced, so the fill level sweeps empty..full
  task automatic test_random_traffic();
    int episode;
    int push_pct;
    int len;
    action_t act;
    episode = 0;
    while (items_sent < RANDOM_ITEMS + 24) begin
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      len = $urandom_range(8, 40);
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        else
          act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        send_cmd(act, rand_word());
      end
      sender_burst = 1'b0;
      if (episode == 0 || $urandom_range(0, 4) == 0) wait_results_drained();
      episode++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pop_on_empty();
    test_push_pop_extremes();
    test_fill_to_overflow();
    test_random_traffic();
    wait_results_drained();
    repeat (4) @(posedge clk);
    $display("Ran %0d transactions: %0d pushes, %0d pops", items_sent, push_count, pop_count);
    $display("Corner hits: %0d pushes into a full queue, %0d pops from an empty queue",
             full_drops, empty_pops);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/double_ended_queue.sv
dv/tb_top.sv
